// ----- hw/rtl/abvh_pkg.sv -----
package abvh_pkg;

    localparam int MAX_COLUMNS  = 2048;
    localparam int BUCKET_COUNT = 10;
    localparam int DEPTH        = MAX_COLUMNS * BUCKET_COUNT;
    localparam int ADDR_W       = $clog2(DEPTH);
    localparam int CNT_W        = $clog2(MAX_COLUMNS + 1);
    localparam int SUM_W        = 52;
    localparam int ITEM_W       = 31;
    localparam int PROD_W       = 29;
    localparam int COLT_W       = $clog2(64'd4294967296 + 64'(MAX_COLUMNS) * 64'd604800);
    localparam int AGE_W        = COLT_W + 1;

    localparam logic [31:0]       BASE_TIME    = 32'd1478403829;
    localparam logic [21:0]       RATE_HEIGHT  = 22'd707000;
    localparam logic [7:0]        LATE_SPACING = 8'd75;
    localparam logic [31:0]       WEEK_SECONDS = 32'd604800;
    localparam logic [SUM_W-1:0]  SUM_MAX      = {SUM_W{1'b1}};

    // late segment: base + rate_height * (early - late) + h * late
    localparam logic [31:0] LATE_BASE = BASE_TIME + 32'(RATE_HEIGHT) * 32'(LATE_SPACING);

    localparam logic [27:0] AGE_LIMITS [9] = '{
        28'd86400, 28'd604800, 28'd2592000, 28'd7776000, 28'd15552000,
        28'd31557600, 28'd63115200, 28'd94672800, 28'd157788000
    };

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic REG_FIRST_TIME = 1'b0;
    localparam logic REG_COL_COUNT  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP,
        ST_ADD,
        ST_DRAIN,
        ST_READ,
        ST_DONE
    } t_state;

    function automatic logic [3:0] age_bucket(input logic [COLT_W-1:0] age);
        logic [3:0] b;
        b = 4'd9;
        for (int i = 8; i >= 0; i--) begin
            if (age < COLT_W'(AGE_LIMITS[i])) begin
                b = 4'(i);
            end
        end
        return b;
    endfunction

endpackage

// ----- hw/rtl/age_bucket_value_histogram.sv -----
// add: one bin read-modify-write for each of the first min(column_count, 2048) columns
// that is not older than the item; read: one bin read when the indices are in range; clear: every bin zeroed
// one item at a time; tready is high only while idle, one result per item
// reset: synchronous, active low; a clearing pass over all 20480 bins follows reset,
// during which no item is taken (configuration writes are taken as ever)
module age_bucket_value_histogram (
    input  logic         i_clk,
    input  logic         i_rst_n,

    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // block_height[21:0], amount[73:22], column_index[84:74], bucket_index[88:85]
    input  logic [95:0]  s_axis_tdata,
    // command[1:0]
    input  logic [1:0]   s_axis_tuser,

    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // bin_sum[51:0]
    output logic [55:0]  m_axis_tdata,
    // saturated[0]
    output logic [0:0]   m_axis_tuser,

    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int ADDR_W = abvh_pkg::ADDR_W;
    localparam int CNT_W  = abvh_pkg::CNT_W;
    localparam int SUM_W  = abvh_pkg::SUM_W;
    localparam int ITEM_W = abvh_pkg::ITEM_W;
    localparam int PROD_W = abvh_pkg::PROD_W;
    localparam int COLT_W = abvh_pkg::COLT_W;
    localparam int AGE_W  = abvh_pkg::AGE_W;

    abvh_pkg::t_state r_state, n_state;

    logic [31:0]        r_first_time;
    logic [11:0]        r_col_count;

    logic [1:0]         r_cmd, n_cmd;
    logic [21:0]        r_height, n_height;
    logic [SUM_W-1:0]   r_amount, n_amount;
    logic [10:0]        r_col_idx, n_col_idx;
    logic [3:0]         r_bkt_idx, n_bkt_idx;
    logic               r_clr_reply, n_clr_reply;
    logic [ADDR_W-1:0]  r_clr_addr, n_clr_addr;

    logic [ITEM_W-1:0]  r_item_time, n_item_time;
    logic [CNT_W-1:0]   r_used, n_used;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [COLT_W-1:0]  r_col_time, n_col_time;
    logic [ADDR_W-1:0]  r_base, n_base;

    logic               r_s1_vld, n_s1_vld;
    logic [AGE_W-1:0]   r_s1_age, n_s1_age;
    logic [ADDR_W-1:0]  r_s1_base, n_s1_base;
    logic               r_s2_vld, n_s2_vld;
    logic [ADDR_W-1:0]  r_s2_addr, n_s2_addr;

    logic               r_rd_ok, n_rd_ok;
    logic               r_out_vld, n_out_vld;
    logic [SUM_W-1:0]   r_out_sum, n_out_sum;
    logic               r_out_sat, n_out_sat;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [SUM_W-1:0]   ram_wdata;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [SUM_W-1:0]   ram_rdata;

    logic [PROD_W-1:0]  height_prod;
    logic [SUM_W:0]     add_sum;
    logic [SUM_W-1:0]   sat_sum;
    logic [3:0]         s1_bucket;
    logic [ADDR_W-1:0]  s1_addr;
    logic               rd_in_range;
    logic [ADDR_W-1:0]  rd_addr;
    logic               in_accept;
    logic               cfg_write;

    abvh_ram #(
        .WIDTH (SUM_W),
        .DEPTH (abvh_pkg::DEPTH)
    ) u_bins (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign in_accept   = s_axis_tvalid && s_axis_tready;
    assign cfg_write   = psel && penable && pwrite && pready;

    assign height_prod = PROD_W'(r_height) * PROD_W'(abvh_pkg::LATE_SPACING);
    assign add_sum     = {1'b0, ram_rdata} + {1'b0, r_amount};
    assign sat_sum     = add_sum[SUM_W] ? abvh_pkg::SUM_MAX : add_sum[SUM_W-1:0];
    assign s1_bucket   = abvh_pkg::age_bucket(r_s1_age[COLT_W-1:0]);
    assign s1_addr     = r_s1_base + ADDR_W'(s1_bucket);
    assign rd_in_range = (32'(r_col_idx) < abvh_pkg::MAX_COLUMNS)
                      && (32'(r_bkt_idx) < abvh_pkg::BUCKET_COUNT);
    assign rd_addr     = ADDR_W'(r_col_idx) * ADDR_W'(abvh_pkg::BUCKET_COUNT)
                       + ADDR_W'(r_bkt_idx);

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_height    = r_height;
        n_amount    = r_amount;
        n_col_idx   = r_col_idx;
        n_bkt_idx   = r_bkt_idx;
        n_clr_reply = r_clr_reply;
        n_clr_addr  = r_clr_addr;
        n_item_time = r_item_time;
        n_used      = r_used;
        n_cnt       = r_cnt;
        n_col_time  = r_col_time;
        n_base      = r_base;
        n_rd_ok     = r_rd_ok;
        n_out_vld   = r_out_vld && !m_axis_tready;
        n_out_sum   = r_out_sum;
        n_out_sat   = r_out_sat;

        // age of the column and base address of its row of buckets
        n_s1_vld    = 1'b0;
        n_s1_age    = $signed({1'b0, r_col_time}) - $signed(AGE_W'(r_item_time));
        n_s1_base   = r_base;

        // columns older than the item are skipped
        n_s2_vld    = r_s1_vld && !r_s1_age[AGE_W-1];
        n_s2_addr   = s1_addr;

        ram_re      = n_s2_vld;
        ram_raddr   = s1_addr;
        ram_we      = r_s2_vld;
        ram_waddr   = r_s2_addr;
        ram_wdata   = sat_sum;

        case (r_state)
            abvh_pkg::ST_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_W'(abvh_pkg::DEPTH - 1)) begin
                    n_clr_addr = '0;
                    n_state    = r_clr_reply ? abvh_pkg::ST_DONE : abvh_pkg::ST_IDLE;
                end
            end
            abvh_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_cmd       = s_axis_tuser;
                    n_height    = s_axis_tdata[21:0];
                    n_amount    = s_axis_tdata[73:22];
                    n_col_idx   = s_axis_tdata[84:74];
                    n_bkt_idx   = s_axis_tdata[88:85];
                    n_clr_reply = 1'b1;
                    n_clr_addr  = '0;
                    case (s_axis_tuser)
                        abvh_pkg::CMD_ADD:   n_state = abvh_pkg::ST_PREP;
                        abvh_pkg::CMD_READ:  n_state = abvh_pkg::ST_READ;
                        abvh_pkg::CMD_CLEAR: n_state = abvh_pkg::ST_CLEAR;
                        default:             n_state = abvh_pkg::ST_DONE;
                    endcase
                end
            end
            abvh_pkg::ST_PREP: begin
                // early spacing is twice the late one
                if (r_height < abvh_pkg::RATE_HEIGHT) begin
                    n_item_time = ITEM_W'(abvh_pkg::BASE_TIME + {height_prod, 1'b0});
                end else begin
                    n_item_time = ITEM_W'(abvh_pkg::LATE_BASE + 32'(height_prod));
                end
                if (32'(r_col_count) < abvh_pkg::MAX_COLUMNS) begin
                    n_used = CNT_W'(r_col_count);
                end else begin
                    n_used = CNT_W'(abvh_pkg::MAX_COLUMNS);
                end
                n_cnt      = '0;
                n_col_time = COLT_W'(r_first_time);
                n_base     = '0;
                n_state    = abvh_pkg::ST_ADD;
            end
            abvh_pkg::ST_ADD: begin
                if (r_cnt < r_used) begin
                    n_s1_vld   = 1'b1;
                    n_cnt      = r_cnt + 1'b1;
                    n_col_time = r_col_time + COLT_W'(abvh_pkg::WEEK_SECONDS);
                    n_base     = r_base + ADDR_W'(abvh_pkg::BUCKET_COUNT);
                end else begin
                    n_state = abvh_pkg::ST_DRAIN;
                end
            end
            abvh_pkg::ST_DRAIN: begin
                if (!r_s1_vld && !r_s2_vld) begin
                    n_state = abvh_pkg::ST_DONE;
                end
            end
            abvh_pkg::ST_READ: begin
                n_rd_ok   = rd_in_range;
                ram_re    = rd_in_range;
                ram_raddr = rd_addr;
                n_state   = abvh_pkg::ST_DONE;
            end
            abvh_pkg::ST_DONE: begin
                if (!r_out_vld || m_axis_tready) begin
                    n_out_vld = 1'b1;
                    if (r_cmd == abvh_pkg::CMD_READ && r_rd_ok) begin
                        n_out_sum = ram_rdata;
                        n_out_sat = (ram_rdata == abvh_pkg::SUM_MAX);
                    end else begin
                        n_out_sum = '0;
                        n_out_sat = 1'b0;
                    end
                    n_state = abvh_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = abvh_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= abvh_pkg::ST_CLEAR;
            r_clr_reply  <= 1'b0;
            r_clr_addr   <= '0;
            r_cmd        <= abvh_pkg::CMD_ADD;
            r_cnt        <= '0;
            r_used       <= '0;
            r_rd_ok      <= 1'b0;
            r_s1_vld     <= 1'b0;
            r_s2_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
            r_first_time <= abvh_pkg::BASE_TIME;
            r_col_count  <= 12'd466;
        end else begin
            r_state     <= n_state;
            r_clr_reply <= n_clr_reply;
            r_clr_addr  <= n_clr_addr;
            r_cmd       <= n_cmd;
            r_cnt       <= n_cnt;
            r_used      <= n_used;
            r_rd_ok     <= n_rd_ok;
            r_s1_vld    <= n_s1_vld;
            r_s2_vld    <= n_s2_vld;
            r_out_vld   <= n_out_vld;
            if (cfg_write) begin
                case (paddr[2])
                    abvh_pkg::REG_FIRST_TIME: r_first_time <= pwdata;
                    abvh_pkg::REG_COL_COUNT:  r_col_count  <= pwdata[11:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_height    <= n_height;
        r_amount    <= n_amount;
        r_col_idx   <= n_col_idx;
        r_bkt_idx   <= n_bkt_idx;
        r_item_time <= n_item_time;
        r_col_time  <= n_col_time;
        r_base      <= n_base;
        r_s1_age    <= n_s1_age;
        r_s1_base   <= n_s1_base;
        r_s2_addr   <= n_s2_addr;
        r_out_sum   <= n_out_sum;
        r_out_sat   <= n_out_sat;
    end

    always_comb begin
        case (paddr[2])
            abvh_pkg::REG_FIRST_TIME: prdata = r_first_time;
            abvh_pkg::REG_COL_COUNT:  prdata = {20'd0, r_col_count};
            default:                  prdata = '0;
        endcase
    end

    assign pready        = 1'b1;
    assign s_axis_tready = (r_state == abvh_pkg::ST_IDLE);
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {4'd0, r_out_sum};
    assign m_axis_tuser  = r_out_sat;

    a_pipe_empty_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (!r_s1_vld && !r_s2_vld))
        else $error("update pipeline busy when an item was taken");

    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("bin read and write at the same address");

    a_stage_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_vld |-> $past(r_s1_vld))
        else $error("write stage without a preceding lookup stage");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == abvh_pkg::ST_IDLE) |-> !ram_we)
        else $error("bin written while idle");

endmodule

// ----- hw/rtl/abvh_ram.sv -----
module abvh_ram #(
    parameter int WIDTH = 52,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
